FILE: design/rbs_pkg.sv
// shared types and constants for the ray against box slab test
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int COORD_W = 32;
  localparam int EXT_W   = COORD_W - 1;
  localparam int NUM_W   = COORD_W + 2;      // slab numerators
  localparam int EDGE_W  = COORD_W + 1;      // box edges before saturation
  localparam int PROD_W  = 2 * COORD_W + 3;  // cross products
  localparam int QUO_W   = COORD_W + 2;      // quotient bits, one per divide cell
  localparam int LO_W    = COORD_W / 2;
  localparam int HI_W    = COORD_W - LO_W;
  localparam int SUM_W   = COORD_W + 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [EXT_W-1:0]          box_width;
    logic [EXT_W-1:0]          box_height;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
  } res_t;

  // what rides along the divide chain
  typedef struct packed {
    logic                      hit;
    logic                      x_entry;
    logic                      neg;
    logic                      ovf;
    logic signed [EDGE_W-1:0]  edge_c;
    logic signed [COORD_W-1:0] base;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [QUO_W-1:0]   dvd;
    logic [QUO_W-1:0]   quo;
    logic [COORD_W-1:0] den;
    side_t              side;
  } div_t;

endpackage

FILE: design/rbs_div_cell.sv
// one restoring divide cell: one quotient bit per transfer
`timescale 1ns / 1ps

module rbs_div_cell
  import rbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn
);

  logic               en;
  logic [COORD_W:0]   trial;
  logic [COORD_W+1:0] diff;
  logic               ge;
  div_t               dn_next;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_comb begin
    trial   = {up.rem, up.dvd[QUO_W-1]};
    diff    = {1'b0, trial} - {2'b00, up.den};
    ge      = !diff[COORD_W+1];
    dn_next = up;
    dn_next.rem = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    dn_next.dvd = {up.dvd[QUO_W-2:0], 1'b0};
    dn_next.quo = {up.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

FILE: design/rbs_front.sv
// slab setup, cross products and hit decision ahead of the divide chain
`timescale 1ns / 1ps

module rbs_front
  import rbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic ray_valid,
  output logic ray_stall,
  input  ray_t ray,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn
);

  typedef struct packed {
    logic                     ok;
    logic                     bnd;
    logic                     neg;
    logic signed [NUM_W-1:0]  near_n;
    logic signed [NUM_W-1:0]  far_n;
    logic [COORD_W-1:0]       den;
    logic signed [EDGE_W-1:0] edge_c;
  } slab_t;

  function automatic slab_t slab_f(input logic signed [COORD_W-1:0] o,
                                   input logic signed [COORD_W-1:0] d,
                                   input logic signed [COORD_W-1:0] lo,
                                   input logic [EXT_W-1:0] ext);
    logic signed [NUM_W-1:0] o_n;
    logic signed [NUM_W-1:0] lo_n;
    logic signed [NUM_W-1:0] hi_n;
    slab_t s;
    o_n  = NUM_W'(o);
    lo_n = NUM_W'(lo);
    hi_n = lo_n + $signed({3'b000, ext});
    s.bnd = d != '0;
    s.neg = d[COORD_W-1];
    s.ok  = (d != '0) || (o_n >= lo_n && o_n <= hi_n);
    s.den = d[COORD_W-1] ? (~d + 1'b1) : d;
    if (d[COORD_W-1]) begin
      s.near_n = o_n - hi_n;
      s.far_n  = o_n - lo_n;
      s.edge_c = hi_n[EDGE_W-1:0];
    end else begin
      s.near_n = lo_n - o_n;
      s.far_n  = hi_n - o_n;
      s.edge_c = lo_n[EDGE_W-1:0];
    end
    return s;
  endfunction

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  slab_t sx1, sy1, sx2, sy2, sx3, sy3;
  logic signed [COORD_W-1:0] ox1, oy1, ox2, oy2, ox3, oy3;

  logic signed [NUM_W-1:0]      num [4];
  logic [COORD_W-1:0]           mul [4];
  logic signed [NUM_W+LO_W:0]   p_lo [4];
  logic signed [NUM_W+HI_W:0]   p_hi [4];
  logic signed [PROD_W-1:0]     prod [4];

  assign en4       = !v4 || dn_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign ray_stall = !en1;
  assign dn_valid  = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= ray_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sx1 <= slab_f(ray.origin_x, ray.dir_x, ray.box_left, ray.box_width);
      sy1 <= slab_f(ray.origin_y, ray.dir_y, ray.box_top, ray.box_height);
      ox1 <= ray.origin_x;
      oy1 <= ray.origin_y;
    end
  end

  // products: near_x*den_y, near_y*den_x, far_x*den_y, far_y*den_x
  always_comb begin
    num[0] = sx1.near_n;  mul[0] = sy1.den;
    num[1] = sy1.near_n;  mul[1] = sx1.den;
    num[2] = sx1.far_n;   mul[2] = sy1.den;
    num[3] = sy1.far_n;   mul[3] = sx1.den;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        p_lo[k] <= num[k] * $signed({1'b0, mul[k][LO_W-1:0]});
        p_hi[k] <= num[k] * $signed({1'b0, mul[k][COORD_W-1:LO_W]});
      end
      sx2 <= sx1;
      sy2 <= sy1;
      ox2 <= ox1;
      oy2 <= oy1;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= PROD_W'(p_lo[k]) + (PROD_W'(p_hi[k]) <<< LO_W);
      end
      sx3 <= sx2;
      sy3 <= sy2;
      ox3 <= ox2;
      oy3 <= oy2;
    end
  end

  logic                     both, x_entry, far_x, before_exit, hit, free;
  logic signed [NUM_W-1:0]  fn;
  logic signed [PROD_W-1:0] psel;
  logic [PROD_W-1:0]        mag;
  logic [COORD_W:0]         high;
  div_t                     dn_next;

  always_comb begin
    both    = sx3.bnd && sy3.bnd;
    free    = !sx3.bnd && !sy3.bnd;
    x_entry = both ? (prod[0] >= prod[1]) : sx3.bnd;
    far_x   = both ? (prod[2] <= prod[3]) : sx3.bnd;
    if (both) begin
      case ({x_entry, far_x})
        2'b11:   before_exit = sx3.near_n < sx3.far_n;
        2'b10:   before_exit = prod[0] < prod[3];
        2'b01:   before_exit = prod[1] < prod[2];
        default: before_exit = sy3.near_n < sy3.far_n;
      endcase
    end else begin
      before_exit = x_entry ? (sx3.near_n < sx3.far_n) : (sy3.near_n < sy3.far_n);
    end
    fn  = far_x ? sx3.far_n : sy3.far_n;
    hit = sx3.ok && sy3.ok && (free || (before_exit && !fn[NUM_W-1]));

    psel = x_entry ? prod[0] : prod[1];
    mag  = psel[PROD_W-1] ? PROD_W'(-psel) : PROD_W'(psel);

    dn_next.side.hit     = hit;
    dn_next.side.x_entry = x_entry || free;
    dn_next.den          = x_entry ? sx3.den : sy3.den;
    dn_next.side.edge_c  = x_entry ? sx3.edge_c : sy3.edge_c;
    dn_next.side.base    = x_entry ? oy3 : ox3;
    dn_next.side.neg     = psel[PROD_W-1] ^ (x_entry ? sy3.neg : sx3.neg);
    // no bounded axis: report the origin itself; a miss takes the same path
    if (free || !hit) begin
      mag                 = '0;
      dn_next.den         = COORD_W'(1);
      dn_next.side.edge_c = EDGE_W'(ox3);
      dn_next.side.base   = oy3;
    end
    high             = mag[PROD_W-1:QUO_W];
    dn_next.side.ovf = high >= {1'b0, dn_next.den};
    dn_next.rem      = dn_next.side.ovf ? '0 : high[COORD_W-1:0];
    dn_next.dvd      = mag[QUO_W-1:0];
    dn_next.quo      = '0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      dn <= dn_next;
    end
  end

endmodule

FILE: design/ray_box_slab_intersect.sv
// top level: 2d ray against axis-aligned box, slab method
`timescale 1ns / 1ps

// One ray/box test enters per cycle while the result side does not stall, and
// its result passes through four front stages (slab setup, the split cross
// products and the hit decision), one cell per quotient bit for the 34-bit
// entry offset divide and one output register. A stall on the result side
// holds every full stage ahead of the first empty one in the same cycle, so
// empty stages keep filling while a finished result waits.

module ray_box_slab_intersect
  import rbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic ray_valid,
  output logic ray_stall,
  input  ray_t ray,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic dv  [QUO_W+1];
  logic rdy [QUO_W+1];
  div_t dd  [QUO_W+1];

  rbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ray_valid (ray_valid),
    .ray_stall (ray_stall),
    .ray       (ray),
    .dn_valid  (dv[0]),
    .dn_ready  (rdy[0]),
    .dn        (dd[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rbs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv[i]),
      .up_ready (rdy[i]),
      .up       (dd[i]),
      .dn_valid (dv[i+1]),
      .dn_ready (rdy[i+1]),
      .dn       (dd[i+1])
    );
  end

  function automatic logic signed [COORD_W-1:0] sat_f(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] vmax;
    logic signed [SUM_W-1:0] vmin;
    vmax = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    vmin = -vmax - SUM_W'(1);
    if (v > vmax) return vmax[COORD_W-1:0];
    if (v < vmin) return vmin[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  logic                      out_en;
  div_t                      last;
  logic [QUO_W-1:0]          q;
  logic signed [SUM_W-1:0]   sq;
  logic signed [SUM_W-1:0]   sum;
  logic signed [COORD_W-1:0] c_edge;
  logic signed [COORD_W-1:0] c_sum;
  res_t                      res_next;

  assign out_en       = !res_valid || !res_stall;
  assign rdy[QUO_W]   = out_en;
  assign last         = dd[QUO_W];

  always_comb begin
    // any overflowed quotient saturates the sum anyway
    q      = last.side.ovf ? (QUO_W'(1) << (COORD_W + 1)) : last.quo;
    sq     = last.side.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum    = SUM_W'(last.side.base) + sq;
    c_sum  = sat_f(sum);
    c_edge = sat_f(SUM_W'(last.side.edge_c));
    res_next.hit   = last.side.hit;
    res_next.hit_x = '0;
    res_next.hit_y = '0;
    if (last.side.hit) begin
      res_next.hit_x = last.side.x_entry ? c_edge : c_sum;
      res_next.hit_y = last.side.x_entry ? c_sum : c_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_en) begin
      res_valid <= dv[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |-> res.hit_x == '0 && res.hit_y == '0)
    else $error("miss result carries a nonzero point");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !ray_stall)
    else $error("input stalled while the output is empty");

  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    dv[QUO_W] && out_en |=> res_valid)
    else $error("finished divide lost before the output register");
`endif

endmodule
